FILE: src/mlpbgt_pkg.sv
// ----------------------------------------------------------------------------
// mlpbgt_pkg
// Types, fixed-point helpers, sigmoid table and row micro-program for the
// two-layer perceptron batch trainer.
// ----------------------------------------------------------------------------
package mlpbgt_pkg;

    localparam int FEATURES    = 2;
    localparam int MAX_ROWS    = 64;
    localparam int FRAC_BITS   = 16;
    localparam int SIG_BITS    = 8;
    localparam int SIG_ENTRIES = 1 << SIG_BITS;
    localparam int SIG_SHIFT   = FRAC_BITS + 4 - SIG_BITS;

    localparam int NPARAM    = FEATURES * FEATURES + 2 * FEATURES + 1;
    localparam int OUTW_BASE = FEATURES * FEATURES;
    localparam int HB_BASE   = FEATURES * FEATURES + FEATURES;
    localparam int OB_SLOT   = FEATURES * FEATURES + 2 * FEATURES;

    localparam int ROW_W   = 6;
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = 4;
    localparam int STEP_W  = 6;
    localparam int FADDR_W = ROW_W + 1;
    localparam int ROW_LAST = 56;

    localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] HALF_FX = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] MAX32   = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32   = 32'sh80000000;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    localparam logic [16:0] LR_RESET    = 17'd32768;
    localparam logic [15:0] LIMIT_RESET = 16'd500;
    localparam logic [6:0]  ROWS_RESET  = 7'd3;

    typedef enum logic [1:0] {
        FN_LOAD_PARAM = 2'd0,
        FN_LOAD_FEAT  = 2'd1,
        FN_LOAD_LABEL = 2'd2,
        FN_TRAIN      = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_LR    = 2'd0,
        CFG_LIMIT = 2'd1,
        CFG_ROWS  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         param_slot;
        logic [5:0]         row;
        logic               feature;
        logic signed [31:0] value;
        logic               label;
    } t_in;

    typedef struct packed {
        logic [3:0]         out_slot;
        logic signed [31:0] out_value;
        logic [15:0]        epochs_run;
        logic               converged;
        logic               last;
    } t_out;

    typedef enum logic [3:0] {
        SRC_X0, SRC_X1, SRC_H0, SRC_H1, SRC_ERR, SRC_ACC,
        SRC_D, SRC_DH, SRC_LR, SRC_PARAM, SRC_GRAD
    } t_src;

    typedef enum logic [4:0] {
        W_NONE, W_X0, W_X1, W_ACC_PROD, W_ACC_ADDPROD, W_ACC_ADDPARAM,
        W_ACC_SIG, W_ACC_ONE_MINUS, W_H0, W_H1, W_D, W_DH, W_ERR,
        W_GRAD_PROD, W_GRAD_ERR, W_GRAD_DH, W_CLEAR, W_PARAM_UPD
    } t_wop;

    typedef struct packed {
        logic              mul_en;
        t_src              src_a;
        t_src              src_b;
        t_wop              wop;
        logic [SLOT_W-1:0] idx;
    } t_uop;

    typedef struct packed {
        logic              ld_en;
        t_uop              uop;
        logic [ROW_W-1:0]  row;
        logic              feat_sel;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   correct;
        logic signed [31:0] rd_param;
    } t_sts;

    typedef logic signed [31:0] t_sig_tab [SIG_ENTRIES];

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(MAX32))      r = MAX32;
        else if (v < 64'(MIN32)) r = MIN32;
        else                     r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] fadd(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return (s[32] != s[31]) ? (s[32] ? MIN32 : MAX32) : s[31:0];
    endfunction

    function automatic logic signed [31:0] fsub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return (s[32] != s[31]) ? (s[32] ? MIN32 : MAX32) : s[31:0];
    endfunction

    // round half up, floor by the fraction width, saturate
    function automatic logic signed [31:0] fmul_fin(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p + 64'(HALF_FX);
        return sat32(q >>> FRAC_BITS);
    endfunction

    function automatic logic [SIG_BITS-1:0] sig_index(input logic signed [31:0] z);
        logic signed [32:0] t;
        logic [32:0]        sh;
        logic [SIG_BITS-1:0] r;
        t  = {z[31], z} + (33'sd8 <<< FRAC_BITS);
        sh = 33'(t) >> SIG_SHIFT;
        if (t < 0)                          r = '0;
        else if (sh >= 33'(SIG_ENTRIES))    r = SIG_BITS'(SIG_ENTRIES - 1);
        else                                r = sh[SIG_BITS-1:0];
        return r;
    endfunction

    // bit-serial division, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_sig_tab build_sig_table();
        t_sig_tab    tab;
        logic [63:0] pw [SIG_ENTRIES+1];
        logic [63:0] h, sum, term, den, num, s;
        int          m, am;
        h    = (64'd8 << 30) >> SIG_BITS;
        sum  = Q30;
        term = Q30;
        for (int k = 1; k <= 10; k++) begin
            term = udiv64((term * h) >> 30, 64'(k));
            if ((k % 2) == 1) sum = sum - term;
            else              sum = sum + term;
        end
        pw[0] = Q30;
        for (int i = 1; i <= SIG_ENTRIES; i++)
            pw[i] = (pw[i-1] * sum + (Q30 >> 1)) >> 30;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            m   = 2 * i + 1 - SIG_ENTRIES;
            am  = (m < 0) ? -m : m;
            den = Q30 + pw[am];
            num = 64'd1 << (FRAC_BITS + 30);
            s   = udiv64(num + (den >> 1), den);
            if (m < 0) s = (64'd1 << FRAC_BITS) - s;
            tab[i] = s[31:0];
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = build_sig_table();

    function automatic t_uop mk(input int mul, input t_src a, input t_src b,
                                input t_wop w, input int idx);
        t_uop u;
        u.mul_en = (mul != 0);
        u.src_a  = a;
        u.src_b  = b;
        u.wop    = w;
        u.idx    = SLOT_W'(idx);
        return u;
    endfunction

    // per-row micro-program: forward pass, then gradient accumulation
    function automatic t_uop row_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        unique case (step)
            6'd1:  u = mk(0, SRC_X0, SRC_X0, W_X0, 0);
            6'd2:  u = mk(0, SRC_X0, SRC_X0, W_X1, 0);
            6'd3:  u = mk(1, SRC_X0, SRC_PARAM, W_NONE, 0);
            6'd4:  u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd5:  u = mk(1, SRC_X1, SRC_PARAM, W_NONE, FEATURES);
            6'd6:  u = mk(0, SRC_X0, SRC_X0, W_ACC_ADDPROD, 0);
            6'd7:  u = mk(0, SRC_X0, SRC_X0, W_ACC_ADDPARAM, HB_BASE);
            6'd8:  u = mk(0, SRC_X0, SRC_X0, W_ACC_SIG, 0);
            6'd9:  u = mk(0, SRC_X0, SRC_X0, W_H0, 0);
            6'd10: u = mk(1, SRC_X0, SRC_PARAM, W_NONE, 1);
            6'd11: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd12: u = mk(1, SRC_X1, SRC_PARAM, W_NONE, FEATURES + 1);
            6'd13: u = mk(0, SRC_X0, SRC_X0, W_ACC_ADDPROD, 0);
            6'd14: u = mk(0, SRC_X0, SRC_X0, W_ACC_ADDPARAM, HB_BASE + 1);
            6'd15: u = mk(0, SRC_X0, SRC_X0, W_ACC_SIG, 0);
            6'd16: u = mk(0, SRC_X0, SRC_X0, W_H1, 0);
            6'd17: u = mk(1, SRC_H0, SRC_PARAM, W_NONE, OUTW_BASE);
            6'd18: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd19: u = mk(1, SRC_H1, SRC_PARAM, W_NONE, OUTW_BASE + 1);
            6'd20: u = mk(0, SRC_X0, SRC_X0, W_ACC_ADDPROD, 0);
            6'd21: u = mk(0, SRC_X0, SRC_X0, W_ACC_ADDPARAM, OB_SLOT);
            6'd22: u = mk(0, SRC_X0, SRC_X0, W_ACC_SIG, 0);
            6'd23: u = mk(0, SRC_X0, SRC_X0, W_ERR, 0);
            6'd24: u = mk(1, SRC_ERR, SRC_H0, W_NONE, 0);
            6'd25: u = mk(0, SRC_X0, SRC_X0, W_GRAD_PROD, OUTW_BASE);
            6'd26: u = mk(1, SRC_ERR, SRC_H1, W_NONE, 0);
            6'd27: u = mk(0, SRC_X0, SRC_X0, W_GRAD_PROD, OUTW_BASE + 1);
            6'd28: u = mk(0, SRC_X0, SRC_X0, W_GRAD_ERR, OB_SLOT);
            // hidden unit 0 back-propagation
            6'd29: u = mk(0, SRC_H0, SRC_X0, W_ACC_ONE_MINUS, 0);
            6'd30: u = mk(1, SRC_H0, SRC_ACC, W_NONE, 0);
            6'd31: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd32: u = mk(0, SRC_X0, SRC_X0, W_D, 0);
            6'd33: u = mk(1, SRC_ERR, SRC_PARAM, W_NONE, OUTW_BASE);
            6'd34: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd35: u = mk(1, SRC_ACC, SRC_D, W_NONE, 0);
            6'd36: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd37: u = mk(0, SRC_X0, SRC_X0, W_DH, 0);
            6'd38: u = mk(1, SRC_X0, SRC_DH, W_NONE, 0);
            6'd39: u = mk(0, SRC_X0, SRC_X0, W_GRAD_PROD, 0);
            6'd40: u = mk(1, SRC_X1, SRC_DH, W_NONE, 0);
            6'd41: u = mk(0, SRC_X0, SRC_X0, W_GRAD_PROD, FEATURES);
            6'd42: u = mk(0, SRC_X0, SRC_X0, W_GRAD_DH, HB_BASE);
            // hidden unit 1 back-propagation
            6'd43: u = mk(0, SRC_H1, SRC_X0, W_ACC_ONE_MINUS, 0);
            6'd44: u = mk(1, SRC_H1, SRC_ACC, W_NONE, 0);
            6'd45: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd46: u = mk(0, SRC_X0, SRC_X0, W_D, 0);
            6'd47: u = mk(1, SRC_ERR, SRC_PARAM, W_NONE, OUTW_BASE + 1);
            6'd48: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd49: u = mk(1, SRC_ACC, SRC_D, W_NONE, 0);
            6'd50: u = mk(0, SRC_X0, SRC_X0, W_ACC_PROD, 0);
            6'd51: u = mk(0, SRC_X0, SRC_X0, W_DH, 0);
            6'd52: u = mk(1, SRC_X0, SRC_DH, W_NONE, 0);
            6'd53: u = mk(0, SRC_X0, SRC_X0, W_GRAD_PROD, 1);
            6'd54: u = mk(1, SRC_X1, SRC_DH, W_NONE, 0);
            6'd55: u = mk(0, SRC_X0, SRC_X0, W_GRAD_PROD, FEATURES + 1);
            6'd56: u = mk(0, SRC_X0, SRC_X0, W_GRAD_DH, HB_BASE + 1);
            default: u = mk(0, SRC_X0, SRC_X0, W_NONE, 0);
        endcase
        return u;
    endfunction

endpackage

FILE: src/mlp_batch_gradient_trainer.sv
// Sequence: a load word is written as it is accepted; a train word runs CHECK, then per epoch
// CLEAR, the per-row micro-program of the single shared multiplier for each row, UPD and
// CHECK again; then 9 result words, one per cycle while i_ready is high.
// Throughput: one word at a time; the next input word is taken after the last result.
// Reset: synchronous active low; clears parameters, gradients and control, loads the
// default configuration. Sample memories hold garbage until written; no clearing pass.
// ----------------------------------------------------------------------------
// mlp_batch_gradient_trainer
// Two-layer perceptron trained by full-batch gradient descent in fixed point.
// ----------------------------------------------------------------------------
module mlp_batch_gradient_trainer
    import mlpbgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_wdata
);

    logic [16:0] r_lr;
    logic [15:0] r_limit;
    logic [6:0]  r_rows;
    t_cmd        cmd;
    t_sts        sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= LR_RESET;
            r_limit <= LIMIT_RESET;
            r_rows  <= ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LR:    r_lr    <= i_cfg_wdata;
                CFG_LIMIT: r_limit <= i_cfg_wdata[15:0];
                CFG_ROWS:  r_rows  <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    mlpbgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .i_limit (r_limit),
        .i_rows  (r_rows),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mlpbgt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_data),
        .i_lr    (r_lr),
        .o_sts   (sts)
    );

endmodule

FILE: src/mlpbgt_dp.sv
// ----------------------------------------------------------------------------
// mlpbgt_dp
// Datapath: parameter and gradient registers, sample memories, one shared
// multiplier with a product register, accumulator and sigmoid lookup.
// ----------------------------------------------------------------------------
module mlpbgt_dp
    import mlpbgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in         i_data,
    input  logic [16:0] i_lr,
    output t_sts        o_sts
);

    logic signed [31:0] r_param [NPARAM];
    logic signed [31:0] r_grad  [NPARAM];
    logic signed [31:0] r_feat_mem [MAX_ROWS * FEATURES];
    logic               r_lab_mem  [MAX_ROWS];
    logic signed [31:0] r_feat_rd;
    logic               r_lab_rd;

    logic signed [31:0] r_x0, r_x1, r_h0, r_h1, r_err, r_acc, r_d, r_dh;
    logic               r_lab;
    logic [CNT_W-1:0]   r_correct;
    logic signed [63:0] r_prod;

    logic signed [31:0] param_rd, grad_rd, op_a, op_b, fin, lab_fx;
    logic               in_range, pred_one;
    t_uop               u;

    assign u        = i_cmd.uop;
    assign in_range = (u.idx < SLOT_W'(NPARAM));
    assign param_rd = in_range ? r_param[u.idx] : '0;
    assign grad_rd  = in_range ? r_grad[u.idx] : '0;
    assign fin      = fmul_fin(r_prod);
    assign lab_fx   = r_lab ? ONE_FX : '0;
    assign pred_one = (r_acc >= HALF_FX);

    always_comb begin
        unique case (u.src_a)
            SRC_X0:    op_a = r_x0;
            SRC_X1:    op_a = r_x1;
            SRC_H0:    op_a = r_h0;
            SRC_H1:    op_a = r_h1;
            SRC_ERR:   op_a = r_err;
            SRC_ACC:   op_a = r_acc;
            SRC_D:     op_a = r_d;
            SRC_DH:    op_a = r_dh;
            SRC_LR:    op_a = signed'({15'd0, i_lr});
            SRC_PARAM: op_a = param_rd;
            SRC_GRAD:  op_a = grad_rd;
            default:   op_a = '0;
        endcase
    end

    always_comb begin
        unique case (u.src_b)
            SRC_X0:    op_b = r_x0;
            SRC_X1:    op_b = r_x1;
            SRC_H0:    op_b = r_h0;
            SRC_H1:    op_b = r_h1;
            SRC_ERR:   op_b = r_err;
            SRC_ACC:   op_b = r_acc;
            SRC_D:     op_b = r_d;
            SRC_DH:    op_b = r_dh;
            SRC_LR:    op_b = signed'({15'd0, i_lr});
            SRC_PARAM: op_b = param_rd;
            SRC_GRAD:  op_b = grad_rd;
            default:   op_b = '0;
        endcase
    end

    // sample memories: written by loads, read every cycle with registered data
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_en && i_data.func == FN_LOAD_FEAT)
            r_feat_mem[{i_data.row, i_data.feature}] <= i_data.value;
        if (i_cmd.ld_en && i_data.func == FN_LOAD_LABEL)
            r_lab_mem[i_data.row] <= i_data.label;
        r_feat_rd <= r_feat_mem[{i_cmd.row, i_cmd.feat_sel}];
        r_lab_rd  <= r_lab_mem[i_cmd.row];
    end

    always_ff @(posedge i_clk) begin
        if (u.mul_en) r_prod <= 64'(op_a) * 64'(op_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NPARAM; s++) begin
                r_param[s] <= '0;
                r_grad[s]  <= '0;
            end
            r_h0      <= '0;
            r_h1      <= '0;
            r_correct <= '0;
        end else begin
            if (i_cmd.ld_en && i_data.func == FN_LOAD_PARAM &&
                i_data.param_slot < SLOT_W'(NPARAM))
                r_param[i_data.param_slot] <= i_data.value;
            unique case (u.wop)
                W_X0:            r_x0 <= r_feat_rd;
                W_X1: begin
                    r_x1  <= r_feat_rd;
                    r_lab <= r_lab_rd;
                end
                W_ACC_PROD:      r_acc <= fin;
                W_ACC_ADDPROD:   r_acc <= fadd(r_acc, fin);
                W_ACC_ADDPARAM:  r_acc <= fadd(r_acc, param_rd);
                W_ACC_SIG:       r_acc <= SIG_TABLE[sig_index(r_acc)];
                W_ACC_ONE_MINUS: r_acc <= fsub(ONE_FX, op_a);
                W_H0:            r_h0 <= r_acc;
                W_H1:            r_h1 <= r_acc;
                W_D:             r_d  <= r_acc;
                W_DH:            r_dh <= r_acc;
                W_ERR: begin
                    r_err <= r_acc - lab_fx;
                    if (pred_one == r_lab) r_correct <= r_correct + 1'b1;
                end
                W_GRAD_PROD:     if (in_range) r_grad[u.idx] <= fadd(grad_rd, fin);
                W_GRAD_ERR:      if (in_range) r_grad[u.idx] <= fadd(grad_rd, r_err);
                W_GRAD_DH:       if (in_range) r_grad[u.idx] <= fadd(grad_rd, r_dh);
                W_CLEAR: begin
                    for (int s = 0; s < NPARAM; s++) r_grad[s] <= '0;
                    r_correct <= '0;
                end
                W_PARAM_UPD:     if (in_range) r_param[u.idx] <= fsub(param_rd, fin);
                default: ;
            endcase
        end
    end

    assign o_sts.correct  = r_correct;
    assign o_sts.rd_param = param_rd;

endmodule

FILE: src/mlpbgt_ctrl.sv
// ----------------------------------------------------------------------------
// mlpbgt_ctrl
// Controller: load dispatch, epoch loop, per-row micro-program sequencing,
// parameter update sweep and the report run.
// ----------------------------------------------------------------------------
module mlpbgt_ctrl
    import mlpbgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic [15:0] i_limit,
    input  logic [6:0]  i_rows,
    input  t_sts        i_sts,
    output t_cmd        o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_CLEAR  = 6'b000100,
        S_ROW    = 6'b001000,
        S_UPD    = 6'b010000,
        S_REPORT = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_phase, n_phase;
    logic [15:0]       r_epoch, n_epoch;
    logic              r_conv, n_conv;

    logic [CNT_W-1:0]  rows;
    logic              accept, last_slot;

    assign rows = (i_rows == '0) ? CNT_W'(1) :
                  (i_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : i_rows;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign last_slot = (r_slot == SLOT_W'(NPARAM - 1));
    assign o_valid   = (r_state == S_REPORT);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_row   = r_row;
        n_slot  = r_slot;
        n_phase = r_phase;
        n_epoch = r_epoch;
        n_conv  = r_conv;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_data.func == FN_TRAIN) begin
                    n_epoch = '0;
                    n_conv  = 1'b0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_slot = '0;
                priority if (r_epoch == i_limit) begin
                    n_state = S_REPORT;
                end else if (r_epoch != '0 && i_sts.correct == rows) begin
                    n_conv  = 1'b1;
                    n_state = S_REPORT;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                n_row   = '0;
                n_step  = '0;
                n_state = S_ROW;
            end
            S_ROW: begin
                if (r_step == STEP_W'(ROW_LAST)) begin
                    n_step = '0;
                    if ({1'b0, r_row} == rows - 1'b1) begin
                        n_slot  = '0;
                        n_phase = 1'b0;
                        n_state = S_UPD;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_UPD: begin
                n_phase = ~r_phase;
                if (r_phase) begin
                    if (last_slot) begin
                        n_epoch = r_epoch + 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            S_REPORT: begin
                if (i_ready) begin
                    if (last_slot) n_state = S_IDLE;
                    else           n_slot  = r_slot + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_row   <= '0;
            r_slot  <= '0;
            r_phase <= 1'b0;
            r_epoch <= '0;
            r_conv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_row   <= n_row;
            r_slot  <= n_slot;
            r_phase <= n_phase;
            r_epoch <= n_epoch;
            r_conv  <= n_conv;
        end
    end

    always_comb begin
        o_cmd.ld_en    = accept && i_data.func != FN_TRAIN;
        o_cmd.row      = r_row;
        o_cmd.feat_sel = (r_step == STEP_W'(1));
        unique case (r_state)
            S_CLEAR:  o_cmd.uop = mk(0, SRC_X0, SRC_X0, W_CLEAR, 0);
            S_ROW:    o_cmd.uop = row_uop(r_step);
            S_UPD:    o_cmd.uop = r_phase ? mk(0, SRC_X0, SRC_X0, W_PARAM_UPD, int'(r_slot))
                                          : mk(1, SRC_LR, SRC_GRAD, W_NONE, int'(r_slot));
            S_REPORT: o_cmd.uop = mk(0, SRC_X0, SRC_X0, W_NONE, int'(r_slot));
            default:  o_cmd.uop = mk(0, SRC_X0, SRC_X0, W_NONE, 0);
        endcase
    end

    assign o_data.out_slot   = r_slot;
    assign o_data.out_value  = i_sts.rd_param;
    assign o_data.epochs_run = r_epoch;
    assign o_data.converged  = r_conv;
    assign o_data.last       = last_slot;

`ifndef SYNTHESIS
    a_epoch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT) |-> (r_epoch <= i_limit))
        else $error("epoch count past limit in report");
    a_conv_needs_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.converged) |-> (r_epoch != '0))
        else $error("converged with no epoch run");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> ({1'b0, r_row} < rows))
        else $error("row counter past row count");
    a_report_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last) |=> (r_state == S_IDLE))
        else $error("report run did not end after last word");
`endif

endmodule

FILE: verif/mlp_batch_gradient_trainer_tb.sv
// ----------------------------------------------------------------------------
// mlp_batch_gradient_trainer_tb
// Self-checking bench for the perceptron batch trainer. A behavioral copy of
// the network (sigmoid table, saturating fixed point, full-batch updates)
// predicts the nine parameter words of every train word. Both handshake
// sides idle at random in bursts. Each result word is compared field by field.
// ----------------------------------------------------------------------------
module mlp_batch_gradient_trainer_tb;
    import mlpbgt_pkg::*;

    localparam int  NSLOT        = 9;
    localparam int  NROWS        = 64;
    localparam int  RANDOM_WORDS = 100;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_ready;
    t_in         in_word = '0;
    logic        o_valid;
    logic        out_ready = 1'b1;
    t_out        o_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [16:0] cfg_data = '0;

    mlp_batch_gradient_trainer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_data      (in_word),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_data      (o_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // network shadow
    int          sig_lut [256];
    int          net_w [NSLOT];
    int          feat_mem [2*NROWS];
    bit          label_mem [NROWS];
    int unsigned step_size = 32768;
    int unsigned max_epochs = 500;
    int unsigned rows_used = 3;

    t_out        pending_params [$];
    int          errors = 0;
    int          words_sent = 0;
    int          trains_run = 0;
    int          converged_runs = 0;
    int          results_seen = 0;
    bit          quiet = 1'b0;
    longint      cycles = 0;

    function automatic int sat(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int q_add(int a, int b);
        return sat(longint'(a) + longint'(b));
    endfunction

    function automatic int q_sub(int a, int b);
        return sat(longint'(a) - longint'(b));
    endfunction

    function automatic int q_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return sat(p >>> 16);
    endfunction

    function automatic void build_sigmoid();
        longint unsigned q30, h, sum, term, den, num, s;
        longint unsigned pw [257];
        int m;
        q30  = 64'd1 << 30;
        h    = (64'd8 * q30) / 256;
        sum  = q30;
        term = q30;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * h) >> 30) / longint'(k);
            if (k % 2 == 1) sum = sum - term;
            else            sum = sum + term;
        end
        pw[0] = q30;
        for (int i = 1; i <= 256; i++)
            pw[i] = (pw[i-1] * sum + (q30 >> 1)) >> 30;
        for (int i = 0; i < 256; i++) begin
            m   = 2 * i + 1 - 256;
            den = q30 + pw[(m < 0) ? -m : m];
            num = 64'd1 << 46;
            s   = (num + den / 2) / den;
            if (m < 0) s = (64'd1 << 16) - s;
            sig_lut[i] = int'(s);
        end
    endfunction

    function automatic int sigmoid(int z);
        longint t;
        longint idx;
        t = longint'(z) + (64'sd8 <<< 16);
        if (t < 0) idx = 0;
        else       idx = (t * 256) >>> 20;
        if (idx > 255) idx = 255;
        return sig_lut[idx];
    endfunction

    // one full-batch epoch; returns rows classified correctly
    function automatic int train_epoch(int unsigned nrows);
        int grad [NSLOT];
        int act [2];
        int x0, x1, z, yhat, pred, err, d, dh, good;
        good = 0;
        foreach (grad[s]) grad[s] = 0;
        for (int k = 0; k < nrows; k++) begin
            x0 = feat_mem[2*k];
            x1 = feat_mem[2*k+1];
            for (int j = 0; j < 2; j++) begin
                z = q_add(q_mul(x0, net_w[j]), q_mul(x1, net_w[2+j]));
                act[j] = sigmoid(q_add(z, net_w[6+j]));
            end
            yhat = q_add(q_mul(act[0], net_w[4]), q_mul(act[1], net_w[5]));
            yhat = q_add(yhat, net_w[8]);
            pred = sigmoid(yhat);
            err  = pred - (label_mem[k] ? 65536 : 0);
            for (int j = 0; j < 2; j++)
                grad[4+j] = q_add(grad[4+j], q_mul(err, act[j]));
            grad[8] = q_add(grad[8], err);
            for (int j = 0; j < 2; j++) begin
                d  = q_mul(act[j], q_sub(65536, act[j]));
                dh = q_mul(q_mul(err, net_w[4+j]), d);
                grad[j]   = q_add(grad[j], q_mul(x0, dh));
                grad[2+j] = q_add(grad[2+j], q_mul(x1, dh));
                grad[6+j] = q_add(grad[6+j], dh);
            end
            if ((pred >= 32768) == label_mem[k]) good++;
        end
        foreach (net_w[s]) net_w[s] = q_sub(net_w[s], q_mul(int'(step_size), grad[s]));
        return good;
    endfunction

    function automatic void predict_word(t_in w);
        int unsigned nrows, ep;
        int good;
        bit conv;
        t_out r;
        case (t_func'(w.func))
            FN_LOAD_PARAM: if (w.param_slot < NSLOT) net_w[w.param_slot] = w.value;
            FN_LOAD_FEAT:  feat_mem[2*w.row + w.feature] = w.value;
            FN_LOAD_LABEL: label_mem[w.row] = w.label;
            FN_TRAIN: begin
                nrows = (rows_used == 0) ? 1 : (rows_used > NROWS) ? NROWS : rows_used;
                ep = 0;
                good = 0;
                conv = 1'b0;
                for (int unsigned e = 0; e < max_epochs; e++) begin
                    if (e > 0 && good == nrows) begin
                        conv = 1'b1;
                        break;
                    end
                    good = train_epoch(nrows);
                    ep++;
                end
                trains_run++;
                if (conv) converged_runs++;
                for (int s = 0; s < NSLOT; s++) begin
                    r.out_slot   = 4'(s);
                    r.out_value  = net_w[s];
                    r.epochs_run = 16'(ep);
                    r.converged  = conv;
                    r.last       = (s == NSLOT - 1);
                    pending_params.push_back(r);
                end
            end
        endcase
    endfunction

    // send one word; valid stays high across back-to-back words
    task automatic send_word(t_in w);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_ready);
        predict_word(w);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_params.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 17'(v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_LR:    step_size  = v & 32'h1ffff;
            CFG_LIMIT: max_epochs = v & 32'hffff;
            CFG_ROWS:  rows_used  = v & 32'h7f;
            default: ;
        endcase
    endtask

    function automatic t_in mk_word(t_func f, int slot, int r, bit ft, int v, bit lb);
        t_in w;
        w.func       = f;
        w.param_slot = 4'(slot);
        w.row        = 6'(r);
        w.feature    = ft;
        w.value      = v;
        w.label      = lb;
        return w;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return int'($urandom());
            default: return $urandom_range(0, 524288) - 262144;
        endcase
    endfunction

    task automatic test_fill_samples();
        for (int r = 0; r < NROWS; r++) begin
            send_word(mk_word(FN_LOAD_FEAT, $urandom_range(0, 15), r, 1'b0, rand_value(), 0));
            send_word(mk_word(FN_LOAD_FEAT, $urandom_range(0, 15), r, 1'b1, rand_value(), 0));
            send_word(mk_word(FN_LOAD_LABEL, $urandom_range(0, 15), r, $urandom_range(0, 1),
                              int'($urandom()), $urandom_range(0, 1)));
        end
    endtask

    task automatic test_directed();
        // defaults: half step, short limit to keep the run small
        drain();
        write_reg(CFG_LIMIT, 3);
        for (int s = 0; s < NSLOT; s++)
            send_word(mk_word(FN_LOAD_PARAM, s, 0, 0, (s % 2) ? 32'h7fffffff : 32'h80000000, 0));
        send_word(mk_word(FN_LOAD_PARAM, 15, 63, 1, 32'h12345678, 1));  // slot past the end
        send_word(mk_word(FN_LOAD_PARAM, 9, 0, 0, -1, 0));
        send_word(mk_word(FN_TRAIN, 0, 0, 0, 0, 0));
        // zero epoch limit: parameters reported unchanged
        drain();
        write_reg(CFG_LIMIT, 0);
        send_word(mk_word(FN_TRAIN, 15, 63, 1, -1, 1));
        // all labels one with zero weights: converges after the first epoch
        drain();
        for (int s = 0; s < NSLOT; s++) send_word(mk_word(FN_LOAD_PARAM, s, 0, 0, 0, 0));
        for (int r = 0; r < 4; r++) send_word(mk_word(FN_LOAD_LABEL, 0, r, 0, 0, 1));
        drain();
        write_reg(CFG_LIMIT, 65535);
        write_reg(CFG_ROWS, 0);
        write_reg(CFG_LR, 0);
        send_word(mk_word(FN_TRAIN, 0, 0, 0, 0, 0));
        // limit reached on an all-correct epoch: not converged
        drain();
        write_reg(CFG_LIMIT, 1);
        write_reg(CFG_ROWS, 4);
        send_word(mk_word(FN_TRAIN, 0, 0, 0, 0, 0));
        // widest row count and a step of 1.0
        drain();
        write_reg(CFG_LIMIT, 2);
        write_reg(CFG_ROWS, 64);
        write_reg(CFG_LR, 65536);
        send_word(mk_word(FN_LOAD_FEAT, 0, 63, 1, 32'h7fffffff, 0));
        send_word(mk_word(FN_LOAD_LABEL, 0, 63, 0, 0, 0));
        send_word(mk_word(FN_TRAIN, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_ROWS, 127);
        send_word(mk_word(FN_TRAIN, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random();
        int pick;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS * 85 / 100) quiet = 1'b1;
            if (n % 50 == 0) begin
                drain();  // hold off until every result is back
                write_reg(CFG_LR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                               : $urandom_range(0, 65536));
                write_reg(CFG_LIMIT, $urandom_range(0, 12));
                write_reg(CFG_ROWS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                                 : $urandom_range(1, 8));
                if (rows_used > 16) write_reg(CFG_LIMIT, $urandom_range(0, 2));
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_word(mk_word(FN_LOAD_PARAM, $urandom_range(0, 8), $urandom_range(0, 63),
                                  $urandom_range(0, 1), rand_value(), $urandom_range(0, 1)));
            else if (pick < 50)
                send_word(mk_word(FN_LOAD_PARAM, $urandom_range(9, 15), $urandom_range(0, 63),
                                  $urandom_range(0, 1), rand_value(), $urandom_range(0, 1)));
            else if (pick < 72)
                send_word(mk_word(FN_LOAD_FEAT, $urandom_range(0, 15), $urandom_range(0, 63),
                                  $urandom_range(0, 1), rand_value(), $urandom_range(0, 1)));
            else if (pick < 84)
                send_word(mk_word(FN_LOAD_LABEL, $urandom_range(0, 15), $urandom_range(0, 63),
                                  $urandom_range(0, 1), rand_value(), $urandom_range(0, 1)));
            else
                send_word(mk_word(FN_TRAIN, $urandom_range(0, 15), $urandom_range(0, 63),
                                  $urandom_range(0, 1), rand_value(), $urandom_range(0, 1)));
        end
    endtask

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int hold;
        if (hold != 0) begin
            hold--;
            if (hold == 0) out_ready <= 1'b1;
        end else if (!quiet && i_rst_n && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 14);
            out_ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && out_ready) begin
            results_seen++;
            if (pending_params.size() == 0) begin
                $error("result word with nothing pending: slot %0d", o_data.out_slot);
                errors++;
            end else begin
                e = pending_params.pop_front();
                if (o_data.out_slot !== e.out_slot) begin
                    $error("out_slot exp %0d got %0d", e.out_slot, o_data.out_slot);
                    errors++;
                end
                if (o_data.out_value !== e.out_value) begin
                    $error("out_value exp %0d got %0d", e.out_value, o_data.out_value);
                    errors++;
                end
                if (o_data.epochs_run !== e.epochs_run) begin
                    $error("epochs_run exp %0d got %0d", e.epochs_run, o_data.epochs_run);
                    errors++;
                end
                if (o_data.converged !== e.converged) begin
                    $error("converged exp %0d got %0d", e.converged, o_data.converged);
                    errors++;
                end
                if (o_data.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_data.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d result words pending", pending_params.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        build_sigmoid();
        foreach (net_w[s]) net_w[s] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_samples();
        test_directed();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        if (pending_params.size() != 0) begin
            $error("%0d result words never arrived", pending_params.size());
            errors++;
        end
        $display("sent %0d words, %0d train runs (%0d converged), checked %0d result words",
                 words_sent, trains_run, converged_runs, results_seen);
        $display("covered saturating params, zero/max limits, row clamps, step extremes");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
